/* rtl/core/cbq_pkg.sv */
// Shared types and constants of the cascaded biquad filter core.
`default_nettype none

package cbq_pkg;

   // Widths of the channel fields and of the datapath.
   localparam int SAMPLE_W   = 24;
   localparam int COEF_W     = 32;
   localparam int SIG_W      = 32;
   localparam int DLY_W      = 48;
   localparam int LEVEL_W    = 18;
   localparam int PROD_W     = 64;
   localparam int RND29_W    = 35;
   localparam int RND12_W    = 52;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;

   localparam int COEFS_PER_SECTION = 5;

   // Request modes.
   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_COEF   = 1'b1;

   // Coefficient slots within one section.
   localparam logic [2:0] COEF_B0 = 3'd0;
   localparam logic [2:0] COEF_B1 = 3'd1;
   localparam logic [2:0] COEF_B2 = 3'd2;
   localparam logic [2:0] COEF_A1 = 3'd3;
   localparam logic [2:0] COEF_A2 = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_SECTIONS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INPUT_LEVEL     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BYPASS          = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCALE,
      ST_SCALE_ACC,
      ST_SECTION,
      ST_FINISH
   } state_type;

   // Steps of one section. The step code doubles as the coefficient slot
   // fetched in that step for the first five steps.
   typedef enum logic [2:0] {
      STEP_FETCH,
      STEP_MUL_B0,
      STEP_Y,
      STEP_T1,
      STEP_T2,
      STEP_D1,
      STEP_WRITE
   } step_type;

endpackage

`default_nettype wire

/* rtl/core/cbq_mul.sv */
// Shared registered 32x32 signed multiplier with the two rounding taps.
`default_nettype none

module cbq_mul
   import cbq_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic signed [SIG_W-1:0]   op_a,
   input  wire logic signed [SIG_W-1:0]   op_b,
   output logic signed [RND29_W-1:0]      rnd29,
   output logic signed [RND12_W-1:0]      rnd12
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] sum29;
   logic signed [PROD_W-1:0] sum12;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // Round to nearest with ties upward, then take the upper bits as a floor shift.
   assign sum29 = prod_ff + (PROD_W'(1) <<< 28);
   assign sum12 = prod_ff + (PROD_W'(1) <<< 11);
   assign rnd29 = sum29[PROD_W-1:29];
   assign rnd12 = sum12[PROD_W-1:12];

endmodule

`default_nettype wire

/* rtl/core/cascaded_biquad_filter_core.sv */
// Top level of the multichannel cascaded biquad filter core.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_stall    mode, channel, sample_in, section,
//                                                coef_index, coef_value
//   rsp_      out        rsp_valid/rsp_stall    out_channel, sample_out, saturated
//   csr_      in         csr_write              csr_index, csr_data
//
// A filtered sample runs the scaling states, then the steps of each active section, then the
// finishing state before it reaches the result register; the pace is set by the
// single shared multiplier doing five products per section. A bypassed sample
// goes straight to the finishing state; a coefficient write is done when taken.
// After reset a clearing pass zeroes the delay and coefficient memories;
// req_stall stays high meanwhile while csr writes are taken.
// One result register parts the channels: a new request is taken while a
// result waits, but the block holds its finished result until it is free.
`default_nettype none

module cascaded_biquad_filter_core
   import cbq_pkg::*;
#(
   parameter int MAX_SECTIONS = 10,
   parameter int NUM_CHANNELS = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_mode,
   input  wire logic [2:0]                   req_channel,
   input  wire logic signed [SAMPLE_W-1:0]   req_sample_in,
   input  wire logic [3:0]                   req_section,
   input  wire logic [2:0]                   req_coef_index,
   input  wire logic signed [COEF_W-1:0]     req_coef_value,

   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [2:0]                        rsp_out_channel,
   output logic signed [SAMPLE_W-1:0]        rsp_sample_out,
   output logic                              rsp_saturated,

   input  wire logic                         csr_write,
   input  wire logic [CSR_IDX_W-1:0]         csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_data
);

   localparam int DLY_DEPTH  = NUM_CHANNELS * MAX_SECTIONS;
   localparam int COEF_DEPTH = MAX_SECTIONS * COEFS_PER_SECTION;
   localparam int CLR_DEPTH  = (DLY_DEPTH > COEF_DEPTH) ? DLY_DEPTH : COEF_DEPTH;
   localparam int DLY_AW     = (DLY_DEPTH > 1) ? $clog2(DLY_DEPTH) : 1;
   localparam int COEF_AW    = $clog2(COEF_DEPTH);
   localparam int CLR_AW     = $clog2(CLR_DEPTH);
   localparam int CNT_W      = $clog2(MAX_SECTIONS + 1);

   // Saturation helpers: keep the value when the dropped upper bits all
   // match the sign, otherwise clamp to the signed limit.
   function automatic logic signed [31:0] sat32_49(input logic signed [48:0] v);
      logic signed [31:0] r;
      if ((&v[48:31]) || !(|v[48:31])) begin
         r = v[31:0];
      end else begin
         r = {v[48], {31{~v[48]}}};
      end
      return r;
   endfunction

   function automatic logic signed [31:0] sat32_52(input logic signed [51:0] v);
      logic signed [31:0] r;
      if ((&v[51:31]) || !(|v[51:31])) begin
         r = v[31:0];
      end else begin
         r = {v[51], {31{~v[51]}}};
      end
      return r;
   endfunction

   function automatic logic signed [47:0] sat48_50(input logic signed [49:0] v);
      logic signed [47:0] r;
      if ((&v[49:47]) || !(|v[49:47])) begin
         r = v[47:0];
      end else begin
         r = {v[49], {47{~v[49]}}};
      end
      return r;
   endfunction

   function automatic logic signed [23:0] clamp24_29(input logic signed [28:0] v);
      logic signed [23:0] r;
      if ((&v[28:23]) || !(|v[28:23])) begin
         r = v[23:0];
      end else begin
         r = {v[28], {23{~v[28]}}};
      end
      return r;
   endfunction

   // Sequencer state.
   state_type               state_ff, state_in;
   step_type                step_ff, step_in;
   logic [CLR_AW-1:0]       clr_ff, clr_in;
   logic [CNT_W-1:0]        sec_ff, sec_in;
   logic [CNT_W-1:0]        n_ff, n_in;

   // Configuration registers.
   logic [3:0]              active_ff, active_in;
   logic [LEVEL_W-1:0]      level_ff, level_in;
   logic                    bypass_ff, bypass_in;

   // Request held for the duration of its work.
   logic [2:0]              ch_ff, ch_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic                    byp_ff, byp_in;

   // Datapath registers.
   logic signed [SIG_W-1:0] acc_ff, acc_in;
   logic signed [SIG_W-1:0] y_ff, y_in;
   logic signed [48:0]      t1_ff, t1_in;
   logic signed [RND29_W-1:0] t2_ff, t2_in;
   logic signed [DLY_W-1:0] d1n_ff, d1n_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              rsp_ch_ff, rsp_ch_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                    rsp_sat_ff, rsp_sat_in;

   // Memories and their registered read data.
   logic signed [COEF_W-1:0] coef_mem [COEF_DEPTH];
   logic signed [DLY_W-1:0]  d1_mem [DLY_DEPTH];
   logic signed [DLY_W-1:0]  d2_mem [DLY_DEPTH];
   logic signed [COEF_W-1:0] coef_rd_ff;
   logic signed [DLY_W-1:0]  d1_rd_ff;
   logic signed [DLY_W-1:0]  d2_rd_ff;

   // Memory port controls.
   logic                    coef_we;
   logic [COEF_AW-1:0]      coef_waddr;
   logic signed [COEF_W-1:0] coef_wdata;
   logic [COEF_AW-1:0]      coef_raddr;
   logic [COEF_AW-1:0]      coef_slot;
   logic                    dly_we;
   logic [DLY_AW-1:0]       dly_waddr;
   logic [DLY_AW-1:0]       dly_addr;
   logic signed [DLY_W-1:0] dly_wd1;
   logic signed [DLY_W-1:0] dly_wd2;

   // Shared multiplier.
   logic signed [SIG_W-1:0]   mul_a;
   logic signed [SIG_W-1:0]   mul_b;
   logic signed [RND29_W-1:0] rnd29;
   logic signed [RND12_W-1:0] rnd12;

   // Miscellaneous decode.
   logic                    req_fire;
   logic                    ch_ok;
   logic                    wr_ok;
   logic [4:0]              act_lim;
   logic [CNT_W-1:0]        n_sel;
   logic                    clr_last;
   logic                    sec_last;
   logic                    out_free;
   logic                    out_load;
   logic signed [48:0]      y_sum;
   logic signed [48:0]      t1_sum;
   logic signed [49:0]      d1_sum;
   logic signed [35:0]      d2_sum;
   logic signed [32:0]      fin_sum;
   logic signed [28:0]      fin_raw;
   logic signed [SAMPLE_W-1:0] fin_clamped;

   cbq_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .rnd29 (rnd29),
      .rnd12 (rnd12)
   );

   // Requests are only taken by an idle sequencer.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && (state_ff == ST_IDLE);

   // Samples of unknown channels are dropped; bad coefficient addresses ignored.
   assign ch_ok = (7'(req_channel) < 7'(NUM_CHANNELS));
   assign wr_ok = (5'(req_section) < 5'(MAX_SECTIONS)) && (req_coef_index <= COEF_A2);

   // A section count above the built depth runs the full cascade.
   assign act_lim = (5'(active_ff) > 5'(MAX_SECTIONS)) ? 5'(MAX_SECTIONS) : 5'(active_ff);
   assign n_sel   = act_lim[CNT_W-1:0];

   assign clr_last = ({1'b0, clr_ff} == (CLR_AW + 1)'(CLR_DEPTH - 1));
   assign sec_last = (CNT_W'(sec_ff + 1'b1) == n_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // The delay pair of a channel and section lives at ch * MAX_SECTIONS + sec.
   assign dly_addr = DLY_AW'(ch_ff) * DLY_AW'(MAX_SECTIONS) + DLY_AW'(sec_ff);

   // The first five steps of a section fetch b0, b1, b2, a1 and a2 in turn.
   assign coef_slot  = ((step_ff == STEP_D1) || (step_ff == STEP_WRITE)) ?
                       COEF_AW'(COEF_B0) : COEF_AW'(step_ff);
   assign coef_raddr = COEF_AW'(sec_ff) * COEF_AW'(COEFS_PER_SECTION) + coef_slot;

   // Section arithmetic on the rounded product of the previous cycle.
   assign y_sum   = {{14{rnd29[RND29_W-1]}}, rnd29} + {d1_rd_ff[DLY_W-1], d1_rd_ff};
   assign t1_sum  = {{14{rnd29[RND29_W-1]}}, rnd29} + {d2_rd_ff[DLY_W-1], d2_rd_ff};
   assign d1_sum  = {t1_ff[48], t1_ff} + {{15{rnd29[RND29_W-1]}}, rnd29};
   assign d2_sum  = {t2_ff[RND29_W-1], t2_ff} + {rnd29[RND29_W-1], rnd29};

   // Final rounding to Q1.23 and clamp.
   assign fin_sum     = {acc_ff[SIG_W-1], acc_ff} + 33'sd8;
   assign fin_raw     = fin_sum[32:4];
   assign fin_clamped = clamp24_29(fin_raw);

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = CLR_AW'(clr_ff + 1'b1);
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && (req_mode == MODE_SAMPLE) && ch_ok) begin
               state_in = bypass_ff ? ST_FINISH : ST_SCALE;
            end
         end
         ST_SCALE: begin
            state_in = ST_SCALE_ACC;
         end
         ST_SCALE_ACC: begin
            step_in  = STEP_FETCH;
            state_in = (n_ff == '0) ? ST_FINISH : ST_SECTION;
         end
         ST_SECTION: begin
            case (step_ff)
               STEP_FETCH:  step_in = STEP_MUL_B0;
               STEP_MUL_B0: step_in = STEP_Y;
               STEP_Y:      step_in = STEP_T1;
               STEP_T1:     step_in = STEP_T2;
               STEP_T2:     step_in = STEP_D1;
               STEP_D1:     step_in = STEP_WRITE;
               STEP_WRITE: begin
                  step_in = STEP_FETCH;
                  if (sec_last) begin
                     state_in = ST_FINISH;
                  end
               end
               default:     step_in = STEP_FETCH;
            endcase
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and memory controls of the sequencer.
   always_comb begin
      sec_in        = sec_ff;
      n_in          = n_ff;
      ch_in         = ch_ff;
      x_in          = x_ff;
      byp_in        = byp_ff;
      acc_in        = acc_ff;
      y_in          = y_ff;
      t1_in         = t1_ff;
      t2_in         = t2_ff;
      d1n_in        = d1n_ff;
      rsp_ch_in     = rsp_ch_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_sat_in    = rsp_sat_ff;
      out_load      = 1'b0;
      coef_we       = 1'b0;
      coef_waddr    = COEF_AW'(req_section) * COEF_AW'(COEFS_PER_SECTION)
                      + COEF_AW'(req_coef_index);
      coef_wdata    = req_coef_value;
      dly_we        = 1'b0;
      dly_waddr     = dly_addr;
      dly_wd1       = d1n_ff;
      dly_wd2       = DLY_W'(d2_sum);
      mul_a         = coef_rd_ff;
      mul_b         = acc_ff;
      case (state_ff)
         ST_CLEAR: begin
            coef_we    = ({1'b0, clr_ff} < (CLR_AW + 1)'(COEF_DEPTH));
            coef_waddr = clr_ff[COEF_AW-1:0];
            coef_wdata = '0;
            dly_we     = ({1'b0, clr_ff} < (CLR_AW + 1)'(DLY_DEPTH));
            dly_waddr  = clr_ff[DLY_AW-1:0];
            dly_wd1    = '0;
            dly_wd2    = '0;
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_mode == MODE_COEF) begin
                  coef_we = wr_ok;
               end else if (ch_ok) begin
                  ch_in  = req_channel;
                  x_in   = req_sample_in;
                  byp_in = bypass_ff;
                  n_in   = n_sel;
                  sec_in = '0;
               end
            end
         end
         ST_SCALE: begin
            mul_a = {{(SIG_W - SAMPLE_W){x_ff[SAMPLE_W-1]}}, x_ff};
            mul_b = $signed({{(SIG_W - LEVEL_W){1'b0}}, level_ff});
         end
         ST_SCALE_ACC: begin
            acc_in = sat32_52(rnd12);
         end
         ST_SECTION: begin
            case (step_ff)
               STEP_Y: begin
                  y_in = sat32_49(y_sum);
               end
               STEP_T1: begin
                  t1_in = t1_sum;
               end
               STEP_T2: begin
                  t2_in = rnd29;
                  mul_b = y_ff;
               end
               STEP_D1: begin
                  d1n_in = sat48_50(d1_sum);
                  mul_b  = y_ff;
               end
               STEP_WRITE: begin
                  dly_we = 1'b1;
                  acc_in = y_ff;
                  sec_in = CNT_W'(sec_ff + 1'b1);
               end
               default: begin
               end
            endcase
         end
         ST_FINISH: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_ch_in     = ch_ff;
               rsp_sample_in = byp_ff ? x_ff : fin_clamped;
               rsp_sat_in    = byp_ff ? 1'b0 : (24'(fin_raw) != fin_clamped) ||
                               (fin_raw != 29'(fin_clamped));
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   // Configuration register writes.
   always_comb begin
      active_in = active_ff;
      level_in  = level_ff;
      bypass_in = bypass_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_ACTIVE_SECTIONS: active_in = csr_data[3:0];
            CSR_INPUT_LEVEL:     level_in  = csr_data;
            CSR_BYPASS:          bypass_in = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         step_ff      <= STEP_FETCH;
         clr_ff       <= '0;
         active_ff    <= 4'd0;
         level_ff     <= LEVEL_W'(65536);
         bypass_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         clr_ff       <= clr_in;
         active_ff    <= active_in;
         level_ff     <= level_in;
         bypass_ff    <= bypass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sec_ff        <= sec_in;
      n_ff          <= n_in;
      ch_ff         <= ch_in;
      x_ff          <= x_in;
      byp_ff        <= byp_in;
      acc_ff        <= acc_in;
      y_ff          <= y_in;
      t1_ff         <= t1_in;
      t2_ff         <= t2_in;
      d1n_ff        <= d1n_in;
      rsp_ch_ff     <= rsp_ch_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   // Coefficient memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= coef_wdata;
      end
      coef_rd_ff <= coef_mem[coef_raddr];
   end

   // Delay memories: both halves of a pair share the address.
   always_ff @(posedge clock) begin
      if (dly_we) begin
         d1_mem[dly_waddr] <= dly_wd1;
         d2_mem[dly_waddr] <= dly_wd2;
      end
      d1_rd_ff <= d1_mem[dly_addr];
      d2_rd_ff <= d2_mem[dly_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_saturated   = rsp_sat_ff;

`ifndef SYNTHESIS
   // The section counter never runs past the cascade length.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SECTION) |-> (sec_ff < n_ff))
      else $error("section counter beyond active cascade length");

   // A finished result is held back while the result register is occupied.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && rsp_stall)
      |=> (state_ff == ST_FINISH && rsp_valid_ff))
      else $error("result register overwritten while stalled");

   // A sample of an unknown channel starts no work.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_mode == MODE_SAMPLE) && !ch_ok) |=> (state_ff == ST_IDLE))
      else $error("dropped sample started the sequencer");

   // A new result only appears from the finishing state.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && rsp_valid_in) |-> (state_ff == ST_FINISH))
      else $error("result loaded outside the finishing state");
`endif

endmodule

`default_nettype wire
